// File: src/ctsm_pkg.sv
`timescale 1ns / 1ps

package ctsm_pkg;

  // Default width of the stored millisecond stamps.
  localparam int TIME_BITS_DEF = 32;

  // Widths fixed by the item fields.
  localparam int LEVEL_W = 10;
  localparam int YEAR_W = 7;
  localparam int MONTH_W = 4;
  localparam int DAY_W = 5;
  localparam int HOUR_W = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int DIGIT_W = 4;
  localparam int MS_W = 16;
  localparam int STAMP_IN_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int BTN_W = 2;

  // Bits of a queued word beyond the timestamp.
  localparam int ITEM_FIXED_BITS = BTN_W + YEAR_W + MONTH_W + DAY_W + HOUR_W
                                   + MINUTE_W + SECOND_W;

  // Register reset values.
  localparam logic [LEVEL_W-1:0] SELECT_THR_RST = 10'd173;
  localparam logic [LEVEL_W-1:0] PLUS_THR_RST = 10'd512;
  localparam logic [LEVEL_W-1:0] MINUS_THR_RST = 10'd851;
  localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [MS_W-1:0] HOLD_RST = 16'd500;
  localparam logic [MS_W-1:0] DISP_INT_RST = 16'd100;

  // Field limits, held at the width of the widest field.
  localparam logic [YEAR_W-1:0] YEAR_HI = 7'd99;
  localparam logic [YEAR_W-1:0] MONTH_HI = 7'd12;
  localparam logic [YEAR_W-1:0] DAY_HI = 7'd31;
  localparam logic [YEAR_W-1:0] HOUR_HI = 7'd23;
  localparam logic [YEAR_W-1:0] MINUTE_HI = 7'd59;
  localparam logic [YEAR_W-1:0] LO_ZERO = 7'd0;
  localparam logic [YEAR_W-1:0] LO_ONE = 7'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SELECT_THR = 3'd0,
    CFG_PLUS_THR   = 3'd1,
    CFG_MINUS_THR  = 3'd2,
    CFG_DEBOUNCE   = 3'd3,
    CFG_HOLD       = 3'd4,
    CFG_DISP_INT   = 3'd5
  } cfg_idx_e;

  // Button classes.
  typedef enum logic [BTN_W-1:0] {
    BTN_NONE   = 2'd0,
    BTN_SELECT = 2'd1,
    BTN_PLUS   = 2'd2,
    BTN_MINUS  = 2'd3
  } btn_e;

  // Menu state, one-hot.
  typedef enum logic [5:0] {
    MODE_RUN    = 6'b000001,
    MODE_YEAR   = 6'b000010,
    MODE_MONTH  = 6'b000100,
    MODE_DAY    = 6'b001000,
    MODE_HOUR   = 6'b010000,
    MODE_MINUTE = 6'b100000
  } mode_e;

  // Tens of a value below 128, by reciprocal multiplication.
  function automatic logic [DIGIT_W-1:0] div10(input logic [YEAR_W-1:0] v);
    logic [17:0] p;
    p = 18'(v) * 18'd205;
    return p[14:11];
  endfunction

  // Units of a value below 128.
  function automatic logic [DIGIT_W-1:0] mod10(input logic [YEAR_W-1:0] v);
    logic [DIGIT_W-1:0] t;
    logic [YEAR_W-1:0] r;
    t = div10(v);
    r = v - YEAR_W'(t) * 7'd10;
    return r[DIGIT_W-1:0];
  endfunction

  // Plus wraps above the high end to the low end; minus at or below the
  // low end wraps to the high end.
  function automatic logic [YEAR_W-1:0] step_field(input logic [YEAR_W-1:0] v,
                                                   input btn_e btn,
                                                   input logic [YEAR_W-1:0] lo,
                                                   input logic [YEAR_W-1:0] hi);
    logic [YEAR_W:0] inc;
    logic [YEAR_W-1:0] res;
    inc = {1'b0, v} + 8'd1;
    case (btn)
      BTN_PLUS: res = (inc > {1'b0, hi}) ? lo : inc[YEAR_W-1:0];
      BTN_MINUS: res = (v <= lo) ? hi : v - 7'd1;
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

// File: src/clock_time_set_menu.sv
`timescale 1ns / 1ps
// Path: a result word leaves after its poll word has passed through the
// two-entry queue and then through the output register.
// Throughput: one word per cycle while the output does not stall.
// Reset: asynchronous, active low; registers return to their defaults, the
// menu returns to running and the shown digits and timestamps clear to zero.
module clock_time_set_menu #(
  parameter int TimeBits = ctsm_pkg::TIME_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ctsm_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ctsm_pkg::MS_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [ctsm_pkg::STAMP_IN_W-1:0]   now_ms_i,
  input  logic [ctsm_pkg::LEVEL_W-1:0]      button_level_i,
  input  logic [ctsm_pkg::YEAR_W-1:0]       rtc_year_i,
  input  logic [ctsm_pkg::MONTH_W-1:0]      rtc_month_i,
  input  logic [ctsm_pkg::DAY_W-1:0]        rtc_day_i,
  input  logic [ctsm_pkg::HOUR_W-1:0]       rtc_hour_i,
  input  logic [ctsm_pkg::MINUTE_W-1:0]     rtc_minute_i,
  input  logic [ctsm_pkg::SECOND_W-1:0]     rtc_second_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [ctsm_pkg::DIGIT_W-1:0]      digit0_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]      digit1_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]      digit2_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]      digit3_o,
  output logic                              time_write_o,
  output logic [ctsm_pkg::YEAR_W-1:0]       set_year_o,
  output logic [ctsm_pkg::MONTH_W-1:0]      set_month_o,
  output logic [ctsm_pkg::DAY_W-1:0]        set_day_o,
  output logic [ctsm_pkg::HOUR_W-1:0]       set_hour_o,
  output logic [ctsm_pkg::MINUTE_W-1:0]     set_minute_o
);

  import ctsm_pkg::*;

  localparam int ItemBits = TimeBits + ITEM_FIXED_BITS;

  logic [LEVEL_W-1:0]  select_thr_q, plus_thr_q, minus_thr_q;
  logic [MS_W-1:0]     debounce_q, hold_q, disp_int_q;
  logic                q_full, q_push, q_valid, q_pop;
  btn_e                front_btn;
  logic [TimeBits-1:0] now_t;
  logic [ItemBits-1:0] q_wdata, q_rdata;
  logic [TimeBits-1:0] b_now;
  logic [BTN_W-1:0]    b_btn;
  logic [YEAR_W-1:0]   b_year;
  logic [MONTH_W-1:0]  b_month;
  logic [DAY_W-1:0]    b_day;
  logic [HOUR_W-1:0]   b_hour;
  logic [MINUTE_W-1:0] b_minute;
  logic [SECOND_W-1:0] b_second;

  // Configuration registers; writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      select_thr_q <= SELECT_THR_RST;
      plus_thr_q   <= PLUS_THR_RST;
      minus_thr_q  <= MINUS_THR_RST;
      debounce_q   <= DEBOUNCE_RST;
      hold_q       <= HOLD_RST;
      disp_int_q   <= DISP_INT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SELECT_THR: select_thr_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_PLUS_THR: plus_thr_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_MINUS_THR: minus_thr_q <= cfg_data_i[LEVEL_W-1:0];
        CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        CFG_HOLD: hold_q <= cfg_data_i;
        CFG_DISP_INT: disp_int_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Front end: classify the ladder level and hand the word to the queue.
  ctsm_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_level_i (button_level_i),
    .select_thr_i   (select_thr_q),
    .plus_thr_i     (plus_thr_q),
    .minus_thr_i    (minus_thr_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .btn_o          (front_btn)
  );

  // Stamps are kept at the configured width.
  assign now_t   = TimeBits'(now_ms_i);
  assign q_wdata = {now_t, front_btn, rtc_year_i, rtc_month_i, rtc_day_i,
                    rtc_hour_i, rtc_minute_i, rtc_second_i};

  ctsm_fifo #(
    .Width (ItemBits)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_rdata)
  );

  assign {b_now, b_btn, b_year, b_month, b_day, b_hour, b_minute, b_second} = q_rdata;

  // Back end: menu state, display refresh and the output register.
  ctsm_back #(
    .TimeBits (TimeBits)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_pop_o   (q_pop),
    .now_i        (b_now),
    .btn_i        (btn_e'(b_btn)),
    .rtc_year_i   (b_year),
    .rtc_month_i  (b_month),
    .rtc_day_i    (b_day),
    .rtc_hour_i   (b_hour),
    .rtc_minute_i (b_minute),
    .rtc_second_i (b_second),
    .debounce_i   (debounce_q),
    .hold_i       (hold_q),
    .disp_int_i   (disp_int_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .digit0_o     (digit0_o),
    .digit1_o     (digit1_o),
    .digit2_o     (digit2_o),
    .digit3_o     (digit3_o),
    .time_write_o (time_write_o),
    .set_year_o   (set_year_o),
    .set_month_o  (set_month_o),
    .set_day_o    (set_day_o),
    .set_hour_o   (set_hour_o),
    .set_minute_o (set_minute_o)
  );

endmodule

// File: src/ctsm_fifo.sv
`timescale 1ns / 1ps

module ctsm_fifo #(
  parameter int Width = 67
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: src/ctsm_front.sv
`timescale 1ns / 1ps

module ctsm_front (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [ctsm_pkg::LEVEL_W-1:0]   button_level_i,
  input  logic [ctsm_pkg::LEVEL_W-1:0]   select_thr_i,
  input  logic [ctsm_pkg::LEVEL_W-1:0]   plus_thr_i,
  input  logic [ctsm_pkg::LEVEL_W-1:0]   minus_thr_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output ctsm_pkg::btn_e                 btn_o
);

  import ctsm_pkg::*;

  // A word is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Threshold tests in fixed order: select, then plus, then minus.
  always_comb begin
    if (button_level_i < select_thr_i) begin
      btn_o = BTN_SELECT;
    end else if (button_level_i < plus_thr_i) begin
      btn_o = BTN_PLUS;
    end else if (button_level_i < minus_thr_i) begin
      btn_o = BTN_MINUS;
    end else begin
      btn_o = BTN_NONE;
    end
  end

endmodule

// File: src/ctsm_back.sv
`timescale 1ns / 1ps

module ctsm_back #(
  parameter int TimeBits = ctsm_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  output logic                            item_pop_o,
  input  logic [TimeBits-1:0]             now_i,
  input  ctsm_pkg::btn_e                  btn_i,
  input  logic [ctsm_pkg::YEAR_W-1:0]     rtc_year_i,
  input  logic [ctsm_pkg::MONTH_W-1:0]    rtc_month_i,
  input  logic [ctsm_pkg::DAY_W-1:0]      rtc_day_i,
  input  logic [ctsm_pkg::HOUR_W-1:0]     rtc_hour_i,
  input  logic [ctsm_pkg::MINUTE_W-1:0]   rtc_minute_i,
  input  logic [ctsm_pkg::SECOND_W-1:0]   rtc_second_i,
  input  logic [ctsm_pkg::MS_W-1:0]       debounce_i,
  input  logic [ctsm_pkg::MS_W-1:0]       hold_i,
  input  logic [ctsm_pkg::MS_W-1:0]       disp_int_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ctsm_pkg::DIGIT_W-1:0]    digit0_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]    digit1_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]    digit2_o,
  output logic [ctsm_pkg::DIGIT_W-1:0]    digit3_o,
  output logic                            time_write_o,
  output logic [ctsm_pkg::YEAR_W-1:0]     set_year_o,
  output logic [ctsm_pkg::MONTH_W-1:0]    set_month_o,
  output logic [ctsm_pkg::DAY_W-1:0]      set_day_o,
  output logic [ctsm_pkg::HOUR_W-1:0]     set_hour_o,
  output logic [ctsm_pkg::MINUTE_W-1:0]   set_minute_o
);

  import ctsm_pkg::*;

  mode_e                 mode_q, mode_d;
  logic [YEAR_W-1:0]     year_q, year_d;
  logic [MONTH_W-1:0]    month_q, month_d;
  logic [DAY_W-1:0]      day_q, day_d;
  logic [HOUR_W-1:0]     hour_q, hour_d;
  logic [MINUTE_W-1:0]   minute_q, minute_d;
  btn_e                  prev_btn_q, prev_btn_d;
  logic [TimeBits-1:0]   press_time_q, press_time_d;
  logic [TimeBits-1:0]   disp_time_q, disp_time_d;
  logic [SECOND_W-1:0]   shown_sec_q, shown_sec_d;
  logic [DIGIT_W-1:0]    dig_q [4];
  logic [DIGIT_W-1:0]    dig_d [4];
  logic [TimeBits-1:0]   since_press, since_disp;
  logic                  press, write;
  logic [YEAR_W-1:0]     field_val;
  logic [DIGIT_W-1:0]    field_idx;
  logic                  out_valid_q;
  logic                  pop;

  // Take a queued word whenever the output register is free or draining.
  assign pop        = item_valid_i && (!out_valid_q || !out_stall_i);
  assign item_pop_o = pop;

  // Button handling: debounce, hold repeat and the menu walk.
  always_comb begin
    mode_d       = mode_q;
    year_d       = year_q;
    month_d      = month_q;
    day_d        = day_q;
    hour_d       = hour_q;
    minute_d     = minute_q;
    prev_btn_d   = prev_btn_q;
    press_time_d = press_time_q;
    write        = 1'b0;
    since_press  = now_i - press_time_q;
    press = ((btn_i != prev_btn_q) && (since_press > TimeBits'(debounce_i)))
            || (since_press > TimeBits'(hold_i));
    if (press) begin
      case (mode_q)
        MODE_RUN: begin
          if (btn_i == BTN_SELECT) begin
            year_d   = rtc_year_i;
            month_d  = rtc_month_i;
            day_d    = rtc_day_i;
            hour_d   = rtc_hour_i;
            minute_d = rtc_minute_i;
            mode_d   = MODE_YEAR;
          end
        end
        MODE_YEAR: begin
          if (btn_i == BTN_SELECT) begin
            mode_d = MODE_MONTH;
          end else begin
            year_d = step_field(year_q, btn_i, LO_ZERO, YEAR_HI);
          end
        end
        MODE_MONTH: begin
          if (btn_i == BTN_SELECT) begin
            mode_d = MODE_DAY;
          end else begin
            month_d = MONTH_W'(step_field(YEAR_W'(month_q), btn_i, LO_ONE, MONTH_HI));
          end
        end
        MODE_DAY: begin
          if (btn_i == BTN_SELECT) begin
            mode_d = MODE_HOUR;
          end else begin
            day_d = DAY_W'(step_field(YEAR_W'(day_q), btn_i, LO_ONE, DAY_HI));
          end
        end
        MODE_HOUR: begin
          if (btn_i == BTN_SELECT) begin
            mode_d = MODE_MINUTE;
          end else begin
            hour_d = HOUR_W'(step_field(YEAR_W'(hour_q), btn_i, LO_ZERO, HOUR_HI));
          end
        end
        MODE_MINUTE: begin
          if (btn_i == BTN_SELECT) begin
            write  = 1'b1;
            mode_d = MODE_RUN;
          end else begin
            minute_d = MINUTE_W'(step_field(YEAR_W'(minute_q), btn_i, LO_ZERO,
                                            MINUTE_HI));
          end
        end
        default: begin
          mode_d = MODE_RUN;
        end
      endcase
      prev_btn_d   = btn_i;
      press_time_d = now_i;
    end
  end

  // Field shown for the menu state after button handling.
  always_comb begin
    case (mode_d)
      MODE_YEAR: begin
        field_idx = 4'd1;
        field_val = year_d;
      end
      MODE_MONTH: begin
        field_idx = 4'd2;
        field_val = YEAR_W'(month_d);
      end
      MODE_DAY: begin
        field_idx = 4'd3;
        field_val = YEAR_W'(day_d);
      end
      MODE_HOUR: begin
        field_idx = 4'd4;
        field_val = YEAR_W'(hour_d);
      end
      MODE_MINUTE: begin
        field_idx = 4'd5;
        field_val = YEAR_W'(minute_d);
      end
      default: begin
        field_idx = 4'd0;
        field_val = '0;
      end
    endcase
  end

  // Display refresh, once per interval.
  always_comb begin
    dig_d       = dig_q;
    shown_sec_d = shown_sec_q;
    disp_time_d = disp_time_q;
    since_disp  = now_i - disp_time_q;
    if (since_disp > TimeBits'(disp_int_i)) begin
      if (mode_d == MODE_RUN) begin
        if (rtc_second_i != shown_sec_q) begin
          dig_d[3]    = mod10(YEAR_W'(rtc_second_i));
          dig_d[2]    = div10(YEAR_W'(rtc_second_i));
          dig_d[1]    = mod10(YEAR_W'(rtc_minute_i));
          dig_d[0]    = div10(YEAR_W'(rtc_minute_i));
          shown_sec_d = rtc_second_i;
        end
      end else begin
        dig_d[0] = field_idx;
        dig_d[1] = 4'd0;
        dig_d[2] = div10(field_val);
        dig_d[3] = mod10(field_val);
      end
      disp_time_d = now_i;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_RUN;
      year_q       <= '0;
      month_q      <= MONTH_W'(1);
      day_q        <= DAY_W'(1);
      hour_q       <= '0;
      minute_q     <= '0;
      prev_btn_q   <= BTN_NONE;
      press_time_q <= '0;
      disp_time_q  <= '0;
      shown_sec_q  <= '0;
      dig_q        <= '{default: '0};
      out_valid_q  <= 1'b0;
    end else begin
      if (pop) begin
        mode_q       <= mode_d;
        year_q       <= year_d;
        month_q      <= month_d;
        day_q        <= day_d;
        hour_q       <= hour_d;
        minute_q     <= minute_d;
        prev_btn_q   <= prev_btn_d;
        press_time_q <= press_time_d;
        disp_time_q  <= disp_time_d;
        shown_sec_q  <= shown_sec_d;
        dig_q        <= dig_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word register; the set fields read zero unless a write is issued.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      time_write_o <= write;
      set_year_o   <= write ? year_d : '0;
      set_month_o  <= write ? month_d : '0;
      set_day_o    <= write ? day_d : '0;
      set_hour_o   <= write ? hour_d : '0;
      set_minute_o <= write ? minute_d : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign digit0_o    = dig_q[0];
  assign digit1_o    = dig_q[1];
  assign digit2_o    = dig_q[2];
  assign digit3_o    = dig_q[3];

endmodule
